[design/pidtw_pkg.sv]
// shared types, constants and helpers for the twiddle-tuned pid controller
package pidtw_pkg;

  localparam int GainCount = 3;
  localparam int GainW     = 32;
  localparam int SampleW   = 16;
  localparam int TotalW    = 40;
  localparam int IdxW      = 2;
  localparam int SatW      = 66;

  typedef logic signed [GainW-1:0] gain_t;
  typedef gain_t gain_arr_t [GainCount];
  typedef logic [IdxW-1:0] gain_idx_t;

  typedef enum logic [1:0] {
    CmdSample  = 2'd0,
    CmdTune    = 2'd1,
    CmdRestart = 2'd2,
    CmdClear   = 2'd3
  } cmd_e;

  // twiddle phase codes
  localparam logic [1:0] DirStart = 2'd0;
  localparam logic [1:0] DirPlus  = 2'd1;
  localparam logic [1:0] DirMinus = 2'd2;

  localparam gain_idx_t LastGain = IdxW'(GainCount - 1);

  localparam gain_arr_t GainReset = '{32'sd13107, 32'sd262, 32'sd196608};
  localparam gain_arr_t StepReset = '{32'sd131, 32'sd2, 32'sd1966};

  // reciprocal multipliers, exact for any 32-bit unsigned dividend
  localparam logic [31:0] Recip10       = 32'hCCCC_CCCD;
  localparam int          Recip10Shift  = 35;
  localparam logic [31:0] Recip100      = 32'h51EB_851F;
  localparam int          Recip100Shift = 37;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [SampleW-1:0] sample;
  } in_t;

  typedef struct packed {
    gain_t            steer;
    logic [TotalW-1:0] total_error;
    logic [1:0]       tune_index;
    logic [1:0]       tune_phase;
    gain_t            gain_p;
    gain_t            gain_i;
    gain_t            gain_d;
  } out_t;

  function automatic gain_t sat_s32(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    gain_t                  r;
    hi = SatW'(32'sh7FFF_FFFF);
    lo = SatW'(32'sh8000_0000);
    priority if (v > hi) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[GainW-1:0];
    end
    return r;
  endfunction

endpackage

[design/pid_with_twiddle_tuning.sv]
// pid controller with twiddle gain tuning, single-pass pipelined datapath
//
//   port group | direction | contents
//   in_*       | input     | cmd, sample (valid/ready)
//   out_*      | output    | steer, total_error, tune state, gains (valid/ready)
//   cfg_*      | input     | gain register index and data (valid/ready)
//
// one transaction per cycle unless the output stalls or the input is held off; a result passes
// through the input snapshot, multiply, sum and output registers.
// a tune transaction is held off while a step rescale is in its final stage.
// a config write holds off the input while gain/100 is formed.
// reset loads the default gains and steps at once; no clearing pass.
module pid_with_twiddle_tuning #(
  parameter int ErrorBits = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pidtw_pkg::in_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pidtw_pkg::out_t      out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  pidtw_pkg::gain_idx_t cfg_index_i,
  input  pidtw_pkg::gain_t     cfg_data_i
);

  localparam int ExtW    = (ErrorBits > pidtw_pkg::TotalW) ? ErrorBits : pidtw_pkg::TotalW;
  localparam int ErrSumW = ErrorBits + 1;
  localparam logic [ErrorBits-1:0] ErrMax = '1;

  typedef struct {
    logic                        is_sample;
    logic signed [15:0]          e;
    logic signed [16:0]          diff;
    pidtw_pkg::gain_t            integ;
    pidtw_pkg::gain_arr_t        gains;
    logic [pidtw_pkg::TotalW-1:0] total;
    pidtw_pkg::gain_idx_t        sel;
    logic [1:0]                  dir;
  } stage_a_t;

  typedef struct {
    logic                        is_sample;
    logic signed [47:0]          prod_p;
    logic signed [48:0]          prod_d;
    logic signed [63:0]          prod_i;
    pidtw_pkg::gain_arr_t        gains;
    logic [pidtw_pkg::TotalW-1:0] total;
    pidtw_pkg::gain_idx_t        sel;
    logic [1:0]                  dir;
  } stage_b_t;

  typedef struct {
    logic                        is_sample;
    logic signed [64:0]          sum;
    pidtw_pkg::gain_arr_t        gains;
    logic [pidtw_pkg::TotalW-1:0] total;
    pidtw_pkg::gain_idx_t        sel;
    logic [1:0]                  dir;
  } stage_c_t;

  typedef struct packed {
    pidtw_pkg::gain_idx_t idx;
    logic                 grow;
    logic                 neg;
    logic [31:0]          mag;
    logic [31:0]          num;
  } job_a_t;

  typedef struct packed {
    pidtw_pkg::gain_idx_t idx;
    logic                 grow;
    logic                 neg;
    logic [31:0]          mag;
    logic [63:0]          prod;
  } job_b_t;

  typedef struct packed {
    pidtw_pkg::gain_idx_t idx;
    logic                 neg;
    logic [31:0]          mag;
  } div_a_t;

  typedef struct packed {
    pidtw_pkg::gain_idx_t idx;
    logic                 neg;
    logic [63:0]          prod;
  } div_b_t;

  // architectural state
  pidtw_pkg::gain_arr_t cfg_q, cfg_d;
  pidtw_pkg::gain_arr_t step_init_q, step_init_d;
  pidtw_pkg::gain_arr_t gains_q, gains_d;
  pidtw_pkg::gain_arr_t steps_q, steps_d;
  logic signed [15:0]   prev_q, prev_d;
  pidtw_pkg::gain_t     integ_q, integ_d;
  logic [ErrorBits-1:0] err_q, err_d;
  logic [ErrorBits-1:0] best_q, best_d;
  pidtw_pkg::gain_idx_t sel_q, sel_d;
  logic [1:0]           dir_q, dir_d;

  // result pipeline
  logic              a_v_q, b_v_q, c_v_q, o_v_q;
  stage_a_t          a_q, a_d;
  stage_b_t          b_q, b_d;
  stage_c_t          c_q, c_d;
  pidtw_pkg::out_t   o_q, o_d;
  logic              ready_a, ready_b, ready_c, ready_o;

  // step rescale and gain/100 units
  logic              ja_v_q, ja_v_d, jb_v_q, jb_v_d;
  job_a_t            ja_q, ja_d;
  job_b_t            jb_q;
  logic              da_v_q, db_v_q;
  div_a_t            da_q, da_d;
  div_b_t            db_q;

  logic              accept;
  logic              cfg_write;
  logic              cfg_busy;
  logic              restart_acc;
  logic              launch_v;
  logic              launch_grow;

  pidtw_pkg::gain_idx_t sel_eff, sel_nxt;
  pidtw_pkg::gain_t     cur_g, cur_s, nxt_g, nxt_s;
  logic signed [32:0]   cur_plus_w, nxt_plus_w;
  logic signed [33:0]   cur_minus_w;
  pidtw_pkg::gain_t     cur_plus, cur_minus, nxt_plus;
  logic [31:0]          cur_mag;
  logic                 less;

  logic signed [16:0]   diff_w;
  logic signed [32:0]   integ_w;
  pidtw_pkg::gain_t     integ_sat;
  logic [15:0]          mag_e;
  logic [ErrorBits:0]   err_w;
  logic [ErrorBits-1:0] err_sat;
  logic [ErrorBits-1:0] total_snap;
  logic [ExtW-1:0]      total_ext;

  logic [28:0]          q10;
  logic [32:0]          res_mag;
  logic signed [33:0]   res_s;
  pidtw_pkg::gain_t     step_new;
  logic [26:0]          q100;
  pidtw_pkg::gain_t     div_abs;
  pidtw_pkg::gain_t     div_val;

  logic signed [64:0]   neg_sum;
  logic signed [64:0]   shr_sum;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && (cfg_index_i <= pidtw_pkg::LastGain);
  assign cfg_busy    = cfg_valid_i || da_v_q || db_v_q;

  assign ready_o = !o_v_q || out_ready_i;
  assign ready_c = !c_v_q || ready_o;
  assign ready_b = !b_v_q || ready_c;
  assign ready_a = !a_v_q || ready_b;

  assign in_ready_o = ready_a && !cfg_busy
                      && !((in_data_i.cmd == pidtw_pkg::CmdTune) && jb_v_q);
  assign accept      = in_valid_i && in_ready_o;
  assign restart_acc = accept && (in_data_i.cmd == pidtw_pkg::CmdRestart);

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_q;

  // twiddle selection
  assign sel_eff = (sel_q > pidtw_pkg::LastGain) ? '0 : sel_q;
  assign sel_nxt = (sel_eff == pidtw_pkg::LastGain) ? '0 : sel_eff + 2'd1;

  always_comb begin
    cur_g = '0;
    cur_s = '0;
    nxt_g = '0;
    nxt_s = '0;
    for (int i = 0; i < pidtw_pkg::GainCount; i++) begin
      if (pidtw_pkg::gain_idx_t'(i) == sel_eff) begin
        cur_g = gains_q[i];
        cur_s = steps_q[i];
      end
      if (pidtw_pkg::gain_idx_t'(i) == sel_nxt) begin
        nxt_g = gains_q[i];
        nxt_s = steps_q[i];
      end
    end
  end

  assign cur_plus_w  = 33'(cur_g) + 33'(cur_s);
  assign nxt_plus_w  = 33'(nxt_g) + 33'(nxt_s);
  assign cur_minus_w = 34'(cur_g) - (34'(cur_s) <<< 1);
  assign cur_plus    = pidtw_pkg::sat_s32(66'(cur_plus_w));
  assign nxt_plus    = pidtw_pkg::sat_s32(66'(nxt_plus_w));
  assign cur_minus   = pidtw_pkg::sat_s32(66'(cur_minus_w));
  assign cur_mag     = cur_s[31] ? 32'(-cur_s) : 32'(cur_s);
  assign less        = err_q < best_q;

  // sample arithmetic
  assign diff_w    = 17'(in_data_i.sample) - 17'(prev_q);
  assign integ_w   = 33'(integ_q) + 33'(in_data_i.sample);
  assign integ_sat = pidtw_pkg::sat_s32(66'(integ_w));
  assign mag_e     = in_data_i.sample[15] ? 16'(-in_data_i.sample) : 16'(in_data_i.sample);
  assign err_w     = {1'b0, err_q} + ErrSumW'(mag_e);
  assign err_sat   = err_w[ErrorBits] ? ErrMax : err_w[ErrorBits-1:0];
  assign total_ext = ExtW'(total_snap);

  // step rescale final stage: 11/10 = m + m/10, 9/10 = m - ceil(m/10)
  assign q10      = jb_q.prod[63:pidtw_pkg::Recip10Shift];
  assign res_mag  = jb_q.grow ? 33'(jb_q.mag) + 33'(q10) : 33'(jb_q.mag) - 33'(q10);
  assign res_s    = jb_q.neg ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
  assign step_new = pidtw_pkg::sat_s32(66'(res_s));

  // gain/100 final stage
  assign q100    = db_q.prod[63:pidtw_pkg::Recip100Shift];
  assign div_abs = 32'(q100);
  assign div_val = db_q.neg ? -div_abs : div_abs;

  // state update
  always_comb begin
    gains_d     = gains_q;
    steps_d     = steps_q;
    prev_d      = prev_q;
    integ_d     = integ_q;
    err_d       = err_q;
    best_d      = best_q;
    sel_d       = sel_q;
    dir_d       = dir_q;
    total_snap  = err_q;
    launch_v    = 1'b0;
    launch_grow = 1'b0;

    if (jb_v_q) begin
      steps_d[jb_q.idx] = step_new;
    end

    if (accept) begin
      unique case (in_data_i.cmd)
        pidtw_pkg::CmdSample: begin
          prev_d     = in_data_i.sample;
          integ_d    = integ_sat;
          err_d      = err_sat;
          total_snap = err_sat;
        end
        pidtw_pkg::CmdTune: begin
          err_d = '0;
          sel_d = sel_eff;
          priority if (dir_q == pidtw_pkg::DirStart) begin
            gains_d[sel_eff] = cur_plus;
            dir_d            = pidtw_pkg::DirPlus;
            if (less) begin
              best_d = err_q;
            end
          end else if (less) begin
            gains_d[sel_nxt] = nxt_plus;
            sel_d            = sel_nxt;
            dir_d            = pidtw_pkg::DirPlus;
            best_d           = err_q;
            launch_v         = 1'b1;
            launch_grow      = 1'b1;
          end else if (dir_q == pidtw_pkg::DirPlus) begin
            gains_d[sel_eff] = cur_minus;
            dir_d            = pidtw_pkg::DirMinus;
          end else begin
            gains_d[sel_eff] = cur_plus;
            gains_d[sel_nxt] = nxt_plus;
            sel_d            = sel_nxt;
            dir_d            = pidtw_pkg::DirPlus;
            launch_v         = 1'b1;
          end
        end
        pidtw_pkg::CmdRestart: begin
          gains_d = cfg_q;
          steps_d = step_init_q;
          prev_d  = '0;
          integ_d = '0;
          err_d   = '0;
          best_d  = ErrMax;
        end
        pidtw_pkg::CmdClear: begin
          err_d = '0;
        end
      endcase
    end
  end

  // rescale job launch, cancelled by restart
  always_comb begin
    ja_v_d      = launch_v;
    jb_v_d      = ja_v_q && !restart_acc;
    ja_d.idx    = sel_eff;
    ja_d.grow   = launch_grow;
    ja_d.neg    = cur_s[31];
    ja_d.mag    = cur_mag;
    ja_d.num    = launch_grow ? cur_mag : cur_mag + 32'd9;
  end

  // config registers and gain/100 launch
  always_comb begin
    cfg_d       = cfg_q;
    step_init_d = step_init_q;
    if (cfg_write) begin
      cfg_d[cfg_index_i] = cfg_data_i;
    end
    if (db_v_q) begin
      step_init_d[db_q.idx] = div_val;
    end
    da_d.idx = cfg_index_i;
    da_d.neg = cfg_data_i[31];
    da_d.mag = cfg_data_i[31] ? 32'(-cfg_data_i) : 32'(cfg_data_i);
  end

  // pipeline payloads
  always_comb begin
    a_d.is_sample = (in_data_i.cmd == pidtw_pkg::CmdSample);
    a_d.e         = in_data_i.sample;
    a_d.diff      = diff_w;
    a_d.integ     = integ_sat;
    a_d.gains     = gains_d;
    a_d.total     = total_ext[pidtw_pkg::TotalW-1:0];
    a_d.sel       = sel_d;
    a_d.dir       = dir_d;

    b_d.is_sample = a_q.is_sample;
    b_d.prod_p    = a_q.gains[0] * a_q.e;
    b_d.prod_d    = a_q.gains[2] * a_q.diff;
    b_d.prod_i    = a_q.gains[1] * a_q.integ;
    b_d.gains     = a_q.gains;
    b_d.total     = a_q.total;
    b_d.sel       = a_q.sel;
    b_d.dir       = a_q.dir;

    c_d.is_sample = b_q.is_sample;
    c_d.sum       = 65'(b_q.prod_p) + 65'(b_q.prod_d) + 65'(b_q.prod_i);
    c_d.gains     = b_q.gains;
    c_d.total     = b_q.total;
    c_d.sel       = b_q.sel;
    c_d.dir       = b_q.dir;
  end

  // negate, floor shift by 8, saturate
  assign neg_sum = -c_q.sum;
  assign shr_sum = neg_sum >>> 8;

  always_comb begin
    o_d.steer       = c_q.is_sample ? pidtw_pkg::sat_s32(66'(shr_sum)) : '0;
    o_d.total_error = c_q.total;
    o_d.tune_index  = c_q.sel;
    o_d.tune_phase  = c_q.dir;
    o_d.gain_p      = c_q.gains[0];
    o_d.gain_i      = c_q.gains[1];
    o_d.gain_d      = c_q.gains[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= pidtw_pkg::GainReset;
      step_init_q <= pidtw_pkg::StepReset;
      gains_q     <= pidtw_pkg::GainReset;
      steps_q     <= pidtw_pkg::StepReset;
      prev_q      <= '0;
      integ_q     <= '0;
      err_q       <= '0;
      best_q      <= ErrMax;
      sel_q       <= '0;
      dir_q       <= pidtw_pkg::DirStart;
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      c_v_q       <= 1'b0;
      o_v_q       <= 1'b0;
      ja_v_q      <= 1'b0;
      jb_v_q      <= 1'b0;
      da_v_q      <= 1'b0;
      db_v_q      <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      step_init_q <= step_init_d;
      gains_q     <= gains_d;
      steps_q     <= steps_d;
      prev_q      <= prev_d;
      integ_q     <= integ_d;
      err_q       <= err_d;
      best_q      <= best_d;
      sel_q       <= sel_d;
      dir_q       <= dir_d;
      if (ready_a) begin
        a_v_q <= accept;
      end
      if (ready_b) begin
        b_v_q <= a_v_q;
      end
      if (ready_c) begin
        c_v_q <= b_v_q;
      end
      if (ready_o) begin
        o_v_q <= c_v_q;
      end
      ja_v_q <= ja_v_d;
      jb_v_q <= jb_v_d;
      da_v_q <= cfg_write;
      db_v_q <= da_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= a_d;
    end
    if (a_v_q && ready_b) begin
      b_q <= b_d;
    end
    if (b_v_q && ready_c) begin
      c_q <= c_d;
    end
    if (c_v_q && ready_o) begin
      o_q <= o_d;
    end
    if (launch_v) begin
      ja_q <= ja_d;
    end
    if (ja_v_q) begin
      jb_q.idx  <= ja_q.idx;
      jb_q.grow <= ja_q.grow;
      jb_q.neg  <= ja_q.neg;
      jb_q.mag  <= ja_q.mag;
      jb_q.prod <= ja_q.num * pidtw_pkg::Recip10;
    end
    if (cfg_write) begin
      da_q <= da_d;
    end
    if (da_v_q) begin
      db_q.idx  <= da_q.idx;
      db_q.neg  <= da_q.neg;
      db_q.prod <= da_q.mag * pidtw_pkg::Recip100;
    end
  end

endmodule

[test/pidtw_scoreboard.sv]
// scoreboard for the twiddle-tuned pid controller: predicts and checks every output transaction
module pidtw_scoreboard
  import pidtw_pkg::*;
#(
  parameter int ErrorBits = 40
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_t       in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_t      out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  gain_idx_t cfg_index_i,
  input  gain_t     cfg_data_i,
  output int        pending_o,
  output int        fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SatHi     = (64'sd1 <<< 31) - 64'sd1;
  localparam longint SatLo     = -(64'sd1 <<< 31);
  localparam longint StepDiv   = 100;
  localparam longint GrowNum   = 11;
  localparam longint ShrinkNum = 9;
  localparam longint RateDen   = 10;
  localparam logic [TotalW-1:0] ErrMax = {TotalW{1'b1}} >> (TotalW - ErrorBits);

  gain_t                     cfg_gain [GainCount];
  gain_t                     gain [GainCount];
  gain_t                     gain_step [GainCount];
  logic signed [SampleW-1:0] prev_err;
  gain_t                     err_integral;
  logic [TotalW-1:0]         err_total;
  logic [TotalW-1:0]         best_total;
  gain_idx_t                 sel;
  logic [1:0]                phase;
  out_t                      ctrl_outputs_q [$];
  int                        fails = 0;

  function automatic gain_t clamp32(input longint v);
    if (v > SatHi) return gain_t'(SatHi);
    if (v < SatLo) return gain_t'(SatLo);
    return gain_t'(v);
  endfunction

  function automatic void reload_gains();
    for (int k = 0; k < GainCount; k++) begin
      gain[k]      = cfg_gain[k];
      gain_step[k] = clamp32(longint'(cfg_gain[k]) / StepDiv);
    end
    prev_err     = '0;
    err_integral = '0;
    err_total    = '0;
    best_total   = ErrMax;
  endfunction

  function automatic void start_gain(input logic [TotalW-1:0] e);
    if (e < best_total) best_total = e;
    phase     = DirPlus;
    gain[sel] = clamp32(longint'(gain[sel]) + longint'(gain_step[sel]));
  endfunction

  function automatic void next_gain();
    phase = DirStart;
    sel   = (sel >= LastGain) ? gain_idx_t'(0) : gain_idx_t'(sel + 1'b1);
  endfunction

  function automatic void tune_gain();
    logic [TotalW-1:0] e;
    e = err_total;
    if (sel > LastGain) sel = '0;
    if (phase == DirStart) begin
      start_gain(e);
    end else if (e < best_total) begin
      gain_step[sel] = clamp32(longint'(gain_step[sel]) * GrowNum / RateDen);
      next_gain();
      start_gain(e);
    end else if (phase == DirPlus) begin
      phase     = DirMinus;
      gain[sel] = clamp32(longint'(gain[sel]) - 2 * longint'(gain_step[sel]));
    end else begin
      gain[sel]      = clamp32(longint'(gain[sel]) + longint'(gain_step[sel]));
      gain_step[sel] = clamp32(longint'(gain_step[sel]) * ShrinkNum / RateDen);
      next_gain();
      start_gain(e);
    end
    err_total = '0;
  endfunction

  function automatic gain_t sample_update(input logic signed [SampleW-1:0] e);
    longint diff;
    longint mag;
    longint sum;
    longint acc;
    diff         = longint'(e) - longint'(prev_err);
    mag          = (e < 0) ? -longint'(e) : longint'(e);
    prev_err     = e;
    err_integral = clamp32(longint'(err_integral) + longint'(e));
    sum          = longint'(err_total) + mag;
    err_total    = (sum > longint'(ErrMax)) ? ErrMax : sum[TotalW-1:0];
    acc = longint'(gain[0]) * longint'(e) + longint'(gain[2]) * diff
        + longint'(gain[1]) * longint'(err_integral);
    acc = -acc;
    return clamp32(acc >>> 8);
  endfunction

  function automatic out_t control_step(input in_t item);
    out_t r;
    r             = '0;
    r.total_error = err_total;
    case (item.cmd)
      CmdSample: begin
        r.steer       = sample_update(item.sample);
        r.total_error = err_total;
      end
      CmdTune:    tune_gain();
      CmdRestart: reload_gains();
      default:    err_total = '0;
    endcase
    r.tune_index = sel;
    r.tune_phase = phase;
    r.gain_p     = gain[0];
    r.gain_i     = gain[1];
    r.gain_d     = gain[2];
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    out_t want;
    if (!rst_ni) begin
      cfg_gain = GainReset;
      sel      = '0;
      phase    = DirStart;
      reload_gains();
      ctrl_outputs_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i <= LastGain) begin
        cfg_gain[cfg_index_i] = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (ctrl_outputs_q.size() == 0) begin
          $error("output transaction with no expected result");
          fails++;
        end else begin
          want = ctrl_outputs_q.pop_front();
          check_field("steer", want.steer, out_data_i.steer);
          check_field("total_error", want.total_error, out_data_i.total_error);
          check_field("tune_index", want.tune_index, out_data_i.tune_index);
          check_field("tune_phase", want.tune_phase, out_data_i.tune_phase);
          check_field("gain_p", want.gain_p, out_data_i.gain_p);
          check_field("gain_i", want.gain_i, out_data_i.gain_i);
          check_field("gain_d", want.gain_d, out_data_i.gain_d);
        end
      end
      if (in_valid_i && in_ready_i) begin
        ctrl_outputs_q.push_back(control_step(in_data_i));
      end
    end
    pending_o <= ctrl_outputs_q.size();
    fails_o   <= fails;
  end

endmodule

[test/pid_with_twiddle_tuning_tb.sv]
// testbench top for the twiddle-tuned pid controller: stimulus, flow control and verdict
module pid_with_twiddle_tuning_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pidtw_pkg::*;

  localparam gain_idx_t RegKp    = 2'd0;
  localparam gain_idx_t RegKi    = 2'd1;
  localparam gain_idx_t RegKd    = 2'd2;
  localparam gain_idx_t RegSpare = 2'd3;

  localparam logic [SampleW-1:0] SampleMax = 16'h7FFF;
  localparam logic [SampleW-1:0] SampleMin = 16'h8000;
  localparam int IntegralRun = 40;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_t       in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_t      out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  gain_idx_t cfg_index_i = '0;
  gain_t     cfg_data_i  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int chk_pending;
  int chk_fails;

  pid_with_twiddle_tuning u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  pidtw_scoreboard u_scoreboard (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i  (in_ready_o),
    .in_data_i,
    .out_valid_i (out_valid_o),
    .out_ready_i,
    .out_data_i  (out_data_o),
    .cfg_valid_i,
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .pending_o   (chk_pending),
    .fails_o     (chk_fails)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_cmd(input cmd_e c, input logic [SampleW-1:0] s);
    int gap = 0;
    in_valid_i <= 1'b1;
    in_data_i  <= '{cmd: c, sample: s};
    do @(posedge clk_i); while (!in_ready_o);
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_op(input cmd_e c);
    send_cmd(c, SampleW'($urandom));
  endtask

  // hold the sender until every expected transaction has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (chk_pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic load_gains(input gain_t kp, input gain_t ki, input gain_t kd);
    gain_idx_t idx [4] = '{RegKp, RegKi, RegKd, RegSpare};
    gain_t     val [4];
    val = '{kp, ki, kd, gain_t'($urandom)};
    cfg_valid_i <= 1'b1;
    foreach (idx[k]) begin
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(input int which);
    case (which)
      0: load_gains($urandom_range(0, 200000), $urandom_range(0, 2000),
                    $urandom_range(0, 400000));
      1: load_gains(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1);
      2: load_gains($urandom, $urandom, $urandom);
      3: load_gains(32'sh8000_0000, 32'sh7FFF_FFFF, '0);
      4: load_gains(gain_t'($urandom_range(0, 800000) - 400000),
                    gain_t'($urandom_range(0, 8000) - 4000),
                    gain_t'($urandom_range(0, 800000) - 400000));
      default: load_gains(GainReset[0], GainReset[1], GainReset[2]);
    endcase
  endtask

  function automatic logic [SampleW-1:0] pick_sample(input int span);
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? SampleMax : SampleMin;
      1:       return SampleW'($urandom);
      default: return SampleW'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  // mostly sample runs closed by a tune, with stray commands mixed in
  task automatic random_items(input int count);
    int sent = 0;
    int len;
    int span;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 12) begin
        send_op(cmd_e'($urandom_range(0, 3)));
        sent++;
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          send_op(CmdRestart);
          sent++;
        end
        len  = $urandom_range(1, 8);
        span = $urandom_range(1, 4000);
        repeat (len) send_cmd(CmdSample, pick_sample(span));
        send_op(CmdTune);
        sent += len + 1;
        if ($urandom_range(0, 49) == 0) wait_idle();
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(CmdSample, SampleMax);
    send_cmd(CmdSample, SampleMin);
    send_cmd(CmdSample, 16'd0);
    send_cmd(CmdSample, 16'hFFFF);
    send_op(CmdTune);
    send_cmd(CmdSample, 16'd100);
    send_op(CmdTune);
    send_cmd(CmdSample, 16'd200);
    send_op(CmdTune);
    send_cmd(CmdSample, 16'd300);
    send_op(CmdTune);
    send_cmd(CmdSample, 16'd500);
    send_op(CmdTune);
    send_cmd(CmdSample, 16'd40);
    send_op(CmdTune);
    send_cmd(CmdSample, 16'd7);
    send_op(CmdClear);
    send_op(CmdTune);
    send_op(CmdRestart);
    send_cmd(CmdSample, 16'd1);
    send_op(CmdTune);

    for (int p = 0; p < 3; p++) begin
      for (int c = 0; c < 2; c++) begin
        wait_idle();
        send_idle_pct   = (p == 0) ? 20 : (p == 1) ? 66 : 0;
        recv_stall_pct <= (p == 0) ? 66 : (p == 1) ? 20 : 0;
        apply_setting(2 * p + c);
        send_op(CmdRestart);
        random_items(250);
      end
    end

    // full-scale sample runs, both signs
    wait_idle();
    apply_setting(5);
    for (int k = 0; k < 2; k++) begin
      send_op(CmdRestart);
      repeat (IntegralRun) send_cmd(CmdSample, (k == 0) ? SampleMax : SampleMin);
    end

    wait_idle();
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
design/pidtw_pkg.sv
design/pid_with_twiddle_tuning.sv
test/pidtw_scoreboard.sv
test/pid_with_twiddle_tuning_tb.sv
